[hw/rtl/cascaded_sine_voltage_current_pid_unit_assert.svh]
// ----------------------------------------------------------------------------
// cascaded sine voltage/current pid unit - assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CASCADED_SINE_VOLTAGE_CURRENT_PID_UNIT_ASSERT_SVH
`define CASCADED_SINE_VOLTAGE_CURRENT_PID_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define CSPVC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CSPVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cspvc_pkg.sv]
// ----------------------------------------------------------------------------
// cspvc_pkg
// types, codes and fixed constants of the cascaded sine voltage/current pid
// ----------------------------------------------------------------------------
`default_nettype none

package cspvc_pkg;

    localparam int GAIN_W      = 24;
    localparam int AMP_W       = 16;
    localparam int SAMPLE_W    = 16;
    localparam int COMPARE_W   = 16;
    localparam int COEF_W      = 26;
    localparam int MUL_A_W     = 27;
    localparam int MUL_B_W     = 32;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int Y_W         = 32;
    localparam int VERR_W      = 17;
    localparam int U_W         = 15;
    localparam int TURN_W      = 16;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;

    localparam int FRAC_SHIFT    = 14;
    localparam int OUTER_SHIFT   = 6;
    localparam int INNER_SHIFT   = 14;
    localparam int COMPARE_SHIFT = 16;

    // sine polynomial, unsigned q14
    localparam logic [U_W-1:0] SINE_ONE = 15'd16384;
    localparam logic [U_W-1:0] SIN_C0   = 15'd77;
    localparam logic [U_W-1:0] SIN_C1   = 15'd1306;
    localparam logic [U_W-1:0] SIN_C2   = 15'd10583;
    localparam logic [U_W-1:0] SIN_C3   = 15'd25736;

    localparam logic signed [MUL_A_W-1:0] COMPARE_GAIN = 27'sd10;

    localparam logic [GAIN_W-1:0] KP_RESET  = 24'd16384;
    localparam logic [GAIN_W-1:0] KI_RESET  = 24'd0;
    localparam logic [GAIN_W-1:0] KD_RESET  = 24'd0;
    localparam logic [AMP_W-1:0]  AMP_RESET = 16'd8688;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_VOLTAGE_KP = 3'd0,
        REG_VOLTAGE_KI = 3'd1,
        REG_VOLTAGE_KD = 3'd2,
        REG_CURRENT_KP = 3'd3,
        REG_CURRENT_KI = 3'd4,
        REG_CURRENT_KD = 3'd5,
        REG_AMPLITUDE  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] voltage_sample;
        logic signed [SAMPLE_W-1:0] current_sample;
    } sample_t;

    typedef struct packed {
        logic [COMPARE_W-1:0] compare_value;
        logic                 compare_clipped;
    } result_t;

    typedef struct packed {
        logic [GAIN_W-1:0] voltage_kp;
        logic [GAIN_W-1:0] voltage_ki;
        logic [GAIN_W-1:0] voltage_kd;
        logic [GAIN_W-1:0] current_kp;
        logic [GAIN_W-1:0] current_ki;
        logic [GAIN_W-1:0] current_kd;
        logic [AMP_W-1:0]  reference_amplitude;
    } cfg_t;

    typedef enum logic [3:0] {
        MUL_NONE  = 4'd0,
        MUL_U_SQ  = 4'd1,
        MUL_SIN0  = 4'd2,
        MUL_SIN1  = 4'd3,
        MUL_SIN2  = 4'd4,
        MUL_SIN3  = 4'd5,
        MUL_AMP   = 4'd6,
        MUL_V0    = 4'd7,
        MUL_V1    = 4'd8,
        MUL_V2    = 4'd9,
        MUL_I0    = 4'd10,
        MUL_I1    = 4'd11,
        MUL_I2    = 4'd12,
        MUL_CMP   = 4'd13
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_SUB  = 2'd2,
        ACC_ADD  = 2'd3
    } acc_op_t;

    typedef struct packed {
        mul_op_t mul_op;
        acc_op_t acc_op;
        logic    capture;
        logic    store_u2;
        logic    store_verr;
        logic    update_outer;
        logic    store_ierr;
        logic    update_inner;
        logic    write_out;
        logic    advance_phase;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/cascaded_sine_voltage_current_pid_unit.sv]
// ----------------------------------------------------------------------------
// cascaded_sine_voltage_current_pid_unit
// sine-referenced cascaded voltage/current pid giving a pwm compare value
// ----------------------------------------------------------------------------
// usage:
//   sample channel (sample_valid/sample_ready/sample) takes one beat per
//   control tick: voltage and current, signed q8.8.
//   result channel (result_valid/result_ready/result) returns one beat per
//   tick: the compare value and its clip flag.
//   gains and the reference amplitude sit on the apb port; the user must
//   write them only while no tick is in flight, the block does not enforce it.
//   a new sample is taken only after the previous sequence has ended, as
//   the single 27x32 multiplier is shared by all steps that the sequencer
//   walks through: sine polynomial, amplitude, both pids and the compare
//   scaling.
//   a stalled result is held in the output register; the next sample is
//   still taken, and its sequence waits at the last step until the held
//   beat leaves.
//   reset: gains return to defaults, phase to zero, pid state is cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_sine_voltage_current_pid_unit
#(
    parameter int STEPS_PER_PERIOD = 400
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  cspvc_pkg::sample_t               sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output cspvc_pkg::result_t               result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cspvc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cspvc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cspvc_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import cspvc_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    cspvc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cspvc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    cspvc_dp
    #(
        .STEPS_PER_PERIOD (STEPS_PER_PERIOD)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

[hw/rtl/cspvc_regs.sv]
// ----------------------------------------------------------------------------
// cspvc_regs
// apb register file holding the loop gains and the reference amplitude
// ----------------------------------------------------------------------------
`default_nettype none

module cspvc_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cspvc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cspvc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cspvc_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    output cspvc_pkg::cfg_t                  cfg
);
    import cspvc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_VOLTAGE_KP: cfg_next.voltage_kp = pwdata[GAIN_W-1:0];
                REG_VOLTAGE_KI: cfg_next.voltage_ki = pwdata[GAIN_W-1:0];
                REG_VOLTAGE_KD: cfg_next.voltage_kd = pwdata[GAIN_W-1:0];
                REG_CURRENT_KP: cfg_next.current_kp = pwdata[GAIN_W-1:0];
                REG_CURRENT_KI: cfg_next.current_ki = pwdata[GAIN_W-1:0];
                REG_CURRENT_KD: cfg_next.current_kd = pwdata[GAIN_W-1:0];
                REG_AMPLITUDE:  cfg_next.reference_amplitude = pwdata[AMP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_VOLTAGE_KP: prdata = {8'd0, cfg_reg.voltage_kp};
            REG_VOLTAGE_KI: prdata = {8'd0, cfg_reg.voltage_ki};
            REG_VOLTAGE_KD: prdata = {8'd0, cfg_reg.voltage_kd};
            REG_CURRENT_KP: prdata = {8'd0, cfg_reg.current_kp};
            REG_CURRENT_KI: prdata = {8'd0, cfg_reg.current_ki};
            REG_CURRENT_KD: prdata = {8'd0, cfg_reg.current_kd};
            REG_AMPLITUDE:  prdata = {16'd0, cfg_reg.reference_amplitude};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voltage_kp          <= KP_RESET;
            cfg_reg.voltage_ki          <= KI_RESET;
            cfg_reg.voltage_kd          <= KD_RESET;
            cfg_reg.current_kp          <= KP_RESET;
            cfg_reg.current_ki          <= KI_RESET;
            cfg_reg.current_kd          <= KD_RESET;
            cfg_reg.reference_amplitude <= AMP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cspvc_ctrl.sv]
// ----------------------------------------------------------------------------
// cspvc_ctrl
// sequencer stepping the datapath through sine, outer pid, inner pid, compare
// ----------------------------------------------------------------------------
`default_nettype none
`include "cascaded_sine_voltage_current_pid_unit_assert.svh"

module cspvc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  cspvc_pkg::dp_status_t status,
    output cspvc_pkg::dp_cmd_t    cmd
);
    import cspvc_pkg::*;

    typedef enum logic [20:0] {
        ST_IDLE = 21'h000001,
        ST_SQ   = 21'h000002,
        ST_H1   = 21'h000004,
        ST_H2   = 21'h000008,
        ST_H3   = 21'h000010,
        ST_H4   = 21'h000020,
        ST_MAG  = 21'h000040,
        ST_VERR = 21'h000080,
        ST_O0   = 21'h000100,
        ST_O1   = 21'h000200,
        ST_O2   = 21'h000400,
        ST_O3   = 21'h000800,
        ST_O4   = 21'h001000,
        ST_IERR = 21'h002000,
        ST_I0   = 21'h004000,
        ST_I1   = 21'h008000,
        ST_I2   = 21'h010000,
        ST_I3   = 21'h020000,
        ST_I4   = 21'h040000,
        ST_CMP  = 21'h080000,
        ST_OUT  = 21'h100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign sample_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.mul_op = MUL_U_SQ;
                state_next = ST_H1;
            end
            ST_H1:
            begin
                cmd.mul_op   = MUL_SIN0;
                cmd.store_u2 = 1'b1;
                state_next   = ST_H2;
            end
            ST_H2:
            begin
                cmd.mul_op = MUL_SIN1;
                state_next = ST_H3;
            end
            ST_H3:
            begin
                cmd.mul_op = MUL_SIN2;
                state_next = ST_H4;
            end
            ST_H4:
            begin
                cmd.mul_op = MUL_SIN3;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.mul_op = MUL_AMP;
                state_next = ST_VERR;
            end
            ST_VERR:
            begin
                cmd.store_verr = 1'b1;
                state_next     = ST_O0;
            end
            ST_O0:
            begin
                cmd.mul_op = MUL_V0;
                state_next = ST_O1;
            end
            ST_O1:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.mul_op = MUL_V1;
                state_next = ST_O2;
            end
            ST_O2:
            begin
                cmd.acc_op = ACC_SUB;
                cmd.mul_op = MUL_V2;
                state_next = ST_O3;
            end
            ST_O3:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_O4;
            end
            ST_O4:
            begin
                cmd.update_outer = 1'b1;
                state_next       = ST_IERR;
            end
            ST_IERR:
            begin
                cmd.store_ierr = 1'b1;
                state_next     = ST_I0;
            end
            ST_I0:
            begin
                cmd.mul_op = MUL_I0;
                state_next = ST_I1;
            end
            ST_I1:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.mul_op = MUL_I1;
                state_next = ST_I2;
            end
            ST_I2:
            begin
                cmd.acc_op = ACC_SUB;
                cmd.mul_op = MUL_I2;
                state_next = ST_I3;
            end
            ST_I3:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_I4;
            end
            ST_I4:
            begin
                cmd.update_inner = 1'b1;
                state_next       = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.mul_op = MUL_CMP;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait here while the previous result is still unread
                if (status.out_free)
                begin
                    cmd.write_out     = 1'b1;
                    cmd.advance_phase = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `CSPVC_ASSERT_SAME(a_ready_no_write, sample_ready, !cmd.write_out && !cmd.advance_phase, "result written while accepting")
    `CSPVC_ASSERT_SAME(a_write_needs_slot, cmd.write_out, status.out_free, "result written into a full slot")
    `CSPVC_ASSERT_NEXT(a_accept_starts, sample_valid && sample_ready, state_reg == ST_SQ, "accepted beat did not start the sequence")

endmodule

`default_nettype wire

[hw/rtl/cspvc_dp.sv]
// ----------------------------------------------------------------------------
// cspvc_dp
// datapath: phase tracker, shared 27x32 multiplier, accumulator, pid state
// ----------------------------------------------------------------------------
`default_nettype none
`include "cascaded_sine_voltage_current_pid_unit_assert.svh"

module cspvc_dp
#(
    parameter int STEPS_PER_PERIOD = 400
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cspvc_pkg::cfg_t       cfg,
    input  cspvc_pkg::sample_t    sample,
    output logic                  result_valid,
    input  logic                  result_ready,
    output cspvc_pkg::result_t    result,
    input  cspvc_pkg::dp_cmd_t    cmd,
    output cspvc_pkg::dp_status_t status
);
    import cspvc_pkg::*;

    localparam int PH_W   = $clog2(STEPS_PER_PERIOD);
    localparam int RM_W   = $clog2(STEPS_PER_PERIOD) + 1;
    localparam int T_STEP = 65536 / STEPS_PER_PERIOD;
    localparam int T_REM  = 65536 % STEPS_PER_PERIOD;

    localparam logic signed [17:0]      VERR_HI = 18'sd65535;
    localparam logic signed [17:0]      VERR_LO = -18'sd65536;
    localparam logic signed [Y_W:0]     IERR_HI = 33'sd2147483647;
    localparam logic signed [Y_W:0]     IERR_LO = -33'sd2147483648;
    localparam logic signed [ACC_W:0]   PID_HI  = 61'sd2147483647;
    localparam logic signed [ACC_W:0]   PID_LO  = -61'sd2147483648;
    localparam logic signed [PROD_W-1:0] CMP_NEG_LIM = -59'sd65536;

    // phase and turn fraction t = floor(phase * 65536 / steps)
    logic [PH_W-1:0]   phase_reg;
    logic [TURN_W-1:0] t_reg;
    logic [RM_W-1:0]   rem_reg;
    logic [RM_W-1:0]   rem_sum;
    logic              rem_carry;

    sample_t sample_reg;

    logic [U_W-1:0] u;
    logic [U_W-1:0] p14;
    logic [U_W-1:0] r_cap;
    logic [U_W-1:0] u2_reg;
    logic [AMP_W-1:0] mag;

    logic [COEF_W-1:0] va0_reg;
    logic [COEF_W-1:0] va1_reg;
    logic [COEF_W-1:0] ia0_reg;
    logic [COEF_W-1:0] ia1_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   prod_ext;

    logic signed [VERR_W-1:0] verr_reg;
    logic signed [VERR_W-1:0] verr_next;
    logic signed [VERR_W-1:0] oh0_reg;
    logic signed [VERR_W-1:0] oh1_reg;
    logic signed [Y_W-1:0]    ierr_reg;
    logic signed [Y_W-1:0]    ierr_next;
    logic signed [Y_W-1:0]    ih0_reg;
    logic signed [Y_W-1:0]    ih1_reg;
    logic signed [Y_W-1:0]    outer_y_reg;
    logic signed [Y_W-1:0]    inner_y_reg;
    logic signed [Y_W-1:0]    pid_y_next;

    logic signed [17:0]    vref;
    logic signed [17:0]    vdiff;
    logic signed [Y_W:0]   idiff;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [ACC_W:0]   pid_sum;
    logic signed [Y_W-1:0]   y_sel;

    logic [COMPARE_W-1:0] cmp_value;
    logic                 cmp_clip;
    logic                 out_valid_reg;
    result_t              out_data_reg;

    assign status.out_free = !out_valid_reg || result_ready;
    assign result_valid    = out_valid_reg;
    assign result          = out_data_reg;

    // ---------------- sine argument ----------------
    assign u     = t_reg[TURN_W-2] ? (SINE_ONE - {1'b0, t_reg[TURN_W-3:0]})
                                   : {1'b0, t_reg[TURN_W-3:0]};
    assign p14   = prod_reg[FRAC_SHIFT+U_W-1:FRAC_SHIFT];
    assign r_cap = (p14 > SINE_ONE) ? SINE_ONE : p14;
    assign mag   = prod_reg[FRAC_SHIFT+AMP_W-1:FRAC_SHIFT];

    assign rem_sum   = rem_reg + RM_W'(T_REM);
    assign rem_carry = (rem_sum >= RM_W'(STEPS_PER_PERIOD));

    // ---------------- multiplier operands ----------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            MUL_U_SQ:
            begin
                mul_a = $signed({12'd0, u});
                mul_b = $signed({17'd0, u});
            end
            MUL_SIN0:
            begin
                mul_a = $signed({12'd0, SIN_C0});
                mul_b = $signed({17'd0, p14});
            end
            MUL_SIN1:
            begin
                mul_a = $signed({12'd0, SIN_C1 - p14});
                mul_b = $signed({17'd0, u2_reg});
            end
            MUL_SIN2:
            begin
                mul_a = $signed({12'd0, SIN_C2 - p14});
                mul_b = $signed({17'd0, u2_reg});
            end
            MUL_SIN3:
            begin
                mul_a = $signed({12'd0, SIN_C3 - p14});
                mul_b = $signed({17'd0, u});
            end
            MUL_AMP:
            begin
                mul_a = $signed({11'd0, cfg.reference_amplitude});
                mul_b = $signed({17'd0, r_cap});
            end
            MUL_V0:
            begin
                mul_a = $signed({1'b0, va0_reg});
                mul_b = {{(MUL_B_W-VERR_W){verr_reg[VERR_W-1]}}, verr_reg};
            end
            MUL_V1:
            begin
                mul_a = $signed({1'b0, va1_reg});
                mul_b = {{(MUL_B_W-VERR_W){oh0_reg[VERR_W-1]}}, oh0_reg};
            end
            MUL_V2:
            begin
                mul_a = $signed({3'd0, cfg.voltage_kd});
                mul_b = {{(MUL_B_W-VERR_W){oh1_reg[VERR_W-1]}}, oh1_reg};
            end
            MUL_I0:
            begin
                mul_a = $signed({1'b0, ia0_reg});
                mul_b = ierr_reg;
            end
            MUL_I1:
            begin
                mul_a = $signed({1'b0, ia1_reg});
                mul_b = ih0_reg;
            end
            MUL_I2:
            begin
                mul_a = $signed({3'd0, cfg.current_kd});
                mul_b = ih1_reg;
            end
            MUL_CMP:
            begin
                mul_a = COMPARE_GAIN;
                mul_b = inner_y_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- errors ----------------
    always_comb
    begin
        vref = t_reg[TURN_W-1] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        vdiff = vref - $signed({{2{sample_reg.voltage_sample[SAMPLE_W-1]}},
                                sample_reg.voltage_sample});
        if (vdiff > VERR_HI)
        begin
            verr_next = VERR_HI[VERR_W-1:0];
        end
        else if (vdiff < VERR_LO)
        begin
            verr_next = VERR_LO[VERR_W-1:0];
        end
        else
        begin
            verr_next = vdiff[VERR_W-1:0];
        end

        idiff = $signed({outer_y_reg[Y_W-1], outer_y_reg})
              - $signed({{9{sample_reg.current_sample[SAMPLE_W-1]}},
                         sample_reg.current_sample, 8'd0});
        if (idiff > IERR_HI)
        begin
            ierr_next = IERR_HI[Y_W-1:0];
        end
        else if (idiff < IERR_LO)
        begin
            ierr_next = IERR_LO[Y_W-1:0];
        end
        else
        begin
            ierr_next = idiff[Y_W-1:0];
        end
    end

    // ---------------- pid output update ----------------
    always_comb
    begin
        acc_sh  = cmd.update_inner ? (acc_reg >>> INNER_SHIFT) : (acc_reg >>> OUTER_SHIFT);
        y_sel   = cmd.update_inner ? inner_y_reg : outer_y_reg;
        pid_sum = $signed({acc_sh[ACC_W-1], acc_sh})
                + $signed({{(ACC_W+1-Y_W){y_sel[Y_W-1]}}, y_sel});
        if (pid_sum > PID_HI)
        begin
            pid_y_next = PID_HI[Y_W-1:0];
        end
        else if (pid_sum < PID_LO)
        begin
            pid_y_next = PID_LO[Y_W-1:0];
        end
        else
        begin
            pid_y_next = pid_sum[Y_W-1:0];
        end
    end

    // ---------------- compare value ----------------
    always_comb
    begin
        prod_ext = $signed({prod_reg[PROD_W-1], prod_reg});
        if (prod_reg <= CMP_NEG_LIM)
        begin
            cmp_value = '0;
            cmp_clip  = 1'b1;
        end
        else if (prod_reg[PROD_W-1])
        begin
            // truncation toward zero lands on zero, not clipped
            cmp_value = '0;
            cmp_clip  = 1'b0;
        end
        else if (|prod_reg[PROD_W-2:COMPARE_SHIFT+COMPARE_W])
        begin
            cmp_value = '1;
            cmp_clip  = 1'b1;
        end
        else
        begin
            cmp_value = prod_reg[COMPARE_SHIFT+COMPARE_W-1:COMPARE_SHIFT];
            cmp_clip  = 1'b0;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        va0_reg <= COEF_W'(cfg.voltage_kp) + COEF_W'(cfg.voltage_ki)
                 + COEF_W'(cfg.voltage_kd);
        va1_reg <= COEF_W'(cfg.voltage_kp) + {1'b0, cfg.voltage_kd, 1'b0};
        ia0_reg <= COEF_W'(cfg.current_kp) + COEF_W'(cfg.current_ki)
                 + COEF_W'(cfg.current_kd);
        ia1_reg <= COEF_W'(cfg.current_kp) + {1'b0, cfg.current_kd, 1'b0};

        if (cmd.capture)
        begin
            sample_reg <= sample;
        end
        if (cmd.mul_op != MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.store_u2)
        begin
            u2_reg <= p14;
        end
        if (cmd.store_verr)
        begin
            verr_reg <= verr_next;
        end
        if (cmd.store_ierr)
        begin
            ierr_reg <= ierr_next;
        end
        unique case (cmd.acc_op)
            ACC_HOLD: acc_reg <= acc_reg;
            ACC_LOAD: acc_reg <= prod_ext;
            ACC_SUB:  acc_reg <= acc_reg - prod_ext;
            ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            default:  acc_reg <= acc_reg;
        endcase
        if (cmd.write_out)
        begin
            out_data_reg.compare_value   <= cmp_value;
            out_data_reg.compare_clipped <= cmp_clip;
        end
    end

    // ---------------- controller-visible state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            t_reg         <= '0;
            rem_reg       <= '0;
            outer_y_reg   <= '0;
            oh0_reg       <= '0;
            oh1_reg       <= '0;
            inner_y_reg   <= '0;
            ih0_reg       <= '0;
            ih1_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.advance_phase)
            begin
                if (phase_reg == PH_W'(STEPS_PER_PERIOD - 1))
                begin
                    phase_reg <= '0;
                    t_reg     <= '0;
                    rem_reg   <= '0;
                end
                else
                begin
                    phase_reg <= phase_reg + PH_W'(1);
                    t_reg     <= t_reg + TURN_W'(T_STEP) + TURN_W'(rem_carry);
                    rem_reg   <= rem_carry ? (rem_sum - RM_W'(STEPS_PER_PERIOD)) : rem_sum;
                end
            end
            if (cmd.update_outer)
            begin
                outer_y_reg <= pid_y_next;
                oh1_reg     <= oh0_reg;
                oh0_reg     <= verr_reg;
            end
            if (cmd.update_inner)
            begin
                inner_y_reg <= pid_y_next;
                ih1_reg     <= ih0_reg;
                ih0_reg     <= ierr_reg;
            end
            if (cmd.write_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `CSPVC_ASSERT_SAME(a_phase_zero_turn, phase_reg == '0, (t_reg == '0) && (rem_reg == '0), "turn fraction out of step with phase")
    `CSPVC_ASSERT_SAME(a_clip_at_bound, result_valid && result.compare_clipped, (result.compare_value == '0) || (result.compare_value == '1), "clipped beat not at a bound")
    `CSPVC_ASSERT_SAME(a_rise_after_write, $rose(out_valid_reg), $past(cmd.write_out), "result valid without a write")
    `CSPVC_ASSERT_SAME(a_phase_holds, !$past(cmd.advance_phase), $stable(phase_reg), "phase moved without advance")

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - cascaded sine voltage/current pid unit
// drives voltage/current sample beats and apb gain writes into the unit, runs
// an in-bench fixed-point model of both pid loops and the sine reference, and
// checks every compare beat field by field against the predicted value
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cspvc_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int STEPS           = 400;
    localparam int IDLE_PERCENT    = 34;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int STEADY_PHASE    = 1;
    localparam int TAIL_CYCLES     = 50;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int PRINT_LIMIT     = 40;

    localparam logic [REG_IDX_W-1:0] UNMAPPED_REG = 3'd7;

    localparam longint Y_MIN        = -64'sd2147483648;
    localparam longint Y_MAX        = 64'sd2147483647;
    localparam longint VERR_MIN     = -64'sd65536;
    localparam longint VERR_MAX     = 64'sd65535;
    localparam longint SAMPLE_MIN   = -64'sd32768;
    localparam longint SAMPLE_MAX   = 64'sd32767;
    localparam longint COMPARE_MAX  = 64'sd65535;
    // inner loop output that lands on a compare value of 20480
    localparam longint DRIVE_TARGET = 64'sd134217728;

    typedef struct {
        int unsigned phase;
        longint      outer_y;
        longint      outer_e1;
        longint      outer_e2;
        longint      inner_y;
        longint      inner_e1;
        longint      inner_e2;
    } loop_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic    sample_valid = 1'b0;
    logic    sample_ready;
    sample_t sample = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cfg_t gain_regs = '{24'd16384, 24'd0, 24'd0, 24'd16384, 24'd0, 24'd0, 16'd8688};

    // model state advanced at each accepted beat, and a second copy advanced
    // as beats are queued so the generator can steer the loops
    loop_state_t tracked_loop = '{0, 0, 0, 0, 0, 0, 0};
    loop_state_t planned_loop = '{0, 0, 0, 0, 0, 0, 0};

    sample_t pending_samples [$];
    result_t expected_compares [$];
    result_t predicted;
    result_t wanted;

    bit steady_flow = 1'b0;
    int mismatches = 0;
    int sample_beats = 0;
    int result_beats = 0;
    int clipped_beats = 0;
    int settings_used = 0;
    int register_writes = 0;
    int quiet_cycles = 0;

    cascaded_sine_voltage_current_pid_unit #(
        .STEPS_PER_PERIOD (STEPS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #(HALF_PERIOD) clk = ~clk;
    end

    function automatic longint clamp_to(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // q1.14 sine from a quadrant-folded polynomial
    function automatic longint sine_at(int unsigned ph);
        longint t;
        longint quad;
        longint x;
        longint u;
        longint u2;
        longint acc;
        longint r;
        t = ((longint'(ph) << 16) / STEPS) & 64'hFFFF;
        quad = t >> 14;
        x = t & 64'h3FFF;
        u = quad[0] ? 64'sd16384 - x : x;
        u2 = (u * u) >> 14;
        acc = 64'sd1306 - ((64'sd77 * u2) >> 14);
        acc = 64'sd10583 - ((acc * u2) >> 14);
        acc = 64'sd25736 - ((acc * u2) >> 14);
        r = (acc * u) >> 14;
        if (r > 64'sd16384)
            r = 64'sd16384;
        return (quad >= 2) ? -r : r;
    endfunction

    function automatic longint reference_at(int unsigned ph);
        longint s;
        longint mag;
        s = sine_at(ph);
        mag = (longint'(gain_regs.reference_amplitude) * ((s < 0) ? -s : s)) >> 14;
        return (s < 0) ? -mag : mag;
    endfunction

    // incremental pid step, floor-shifted to the output scale
    function automatic longint pid_delta(longint kp, longint ki, longint kd, longint e,
                                         longint e1, longint e2, int shift);
        longint acc;
        acc = (kp + ki + kd) * e - (kp + 2 * kd) * e1 + kd * e2;
        return acc >>> shift;
    endfunction

    function automatic result_t control_tick(inout loop_state_t st, input sample_t beat);
        longint  vs;
        longint  cs;
        longint  verr;
        longint  ierr;
        longint  p;
        longint  q;
        result_t r;
        vs = longint'(beat.voltage_sample);
        cs = longint'(beat.current_sample);
        verr = clamp_to(reference_at(st.phase) - vs, VERR_MIN, VERR_MAX);
        st.outer_y = clamp_to(st.outer_y + pid_delta(longint'(gain_regs.voltage_kp),
            longint'(gain_regs.voltage_ki), longint'(gain_regs.voltage_kd), verr,
            st.outer_e1, st.outer_e2, OUTER_SHIFT), Y_MIN, Y_MAX);
        st.outer_e2 = st.outer_e1;
        st.outer_e1 = verr;
        ierr = clamp_to(st.outer_y - cs * 256, Y_MIN, Y_MAX);
        st.inner_y = clamp_to(st.inner_y + pid_delta(longint'(gain_regs.current_kp),
            longint'(gain_regs.current_ki), longint'(gain_regs.current_kd), ierr,
            st.inner_e1, st.inner_e2, INNER_SHIFT), Y_MIN, Y_MAX);
        st.inner_e2 = st.inner_e1;
        st.inner_e1 = ierr;
        // drive times ten, truncated toward zero
        p = st.inner_y * 10;
        q = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
        if (q < 0)
        begin
            r.compare_value = '0;
            r.compare_clipped = 1'b1;
        end
        else if (q > COMPARE_MAX)
        begin
            r.compare_value = '1;
            r.compare_clipped = 1'b1;
        end
        else
        begin
            r.compare_value = q[COMPARE_W-1:0];
            r.compare_clipped = 1'b0;
        end
        st.phase = (st.phase >= STEPS - 1) ? 0 : st.phase + 1;
        return r;
    endfunction

    function automatic bit take_gap();
        return !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    function automatic logic [31:0] pick_gain();
        logic [31:0] word;
        int unsigned roll;
        // upper byte stays random, the unit keeps only the gain width
        word = $urandom;
        roll = $urandom_range(99);
        if (roll < 10)
            word[GAIN_W-1:0] = '0;
        else if (roll < 20)
            word[GAIN_W-1:0] = '1;
        else if (roll >= 35)
            word[GAIN_W-1:0] = 24'($urandom_range(0, 65536));
        return word;
    endfunction

    function automatic logic [31:0] pick_amplitude();
        logic [31:0] word;
        int unsigned roll;
        word = $urandom;
        roll = $urandom_range(99);
        if (roll < 10)
            word[AMP_W-1:0] = '0;
        else if (roll < 20)
            word[AMP_W-1:0] = '1;
        return word;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_VOLTAGE_KP: gain_regs.voltage_kp = data[GAIN_W-1:0];
            REG_VOLTAGE_KI: gain_regs.voltage_ki = data[GAIN_W-1:0];
            REG_VOLTAGE_KD: gain_regs.voltage_kd = data[GAIN_W-1:0];
            REG_CURRENT_KP: gain_regs.current_kp = data[GAIN_W-1:0];
            REG_CURRENT_KI: gain_regs.current_ki = data[GAIN_W-1:0];
            REG_CURRENT_KD: gain_regs.current_kd = data[GAIN_W-1:0];
            REG_AMPLITUDE:  gain_regs.reference_amplitude = data[AMP_W-1:0];
            default:        ;
        endcase
        register_writes++;
    endtask

    task automatic write_all(input logic [31:0] data);
        write_register(REG_VOLTAGE_KP, data);
        write_register(REG_VOLTAGE_KI, data);
        write_register(REG_VOLTAGE_KD, data);
        write_register(REG_CURRENT_KP, data);
        write_register(REG_CURRENT_KI, data);
        write_register(REG_CURRENT_KD, data);
        write_register(REG_AMPLITUDE, data);
        write_register(UNMAPPED_REG, ~data);
        settings_used++;
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] c);
        sample_t s;
        s.voltage_sample = v;
        s.current_sample = c;
        pending_samples.push_back(s);
        void'(control_tick(planned_loop, s));
    endtask

    // mostly small errors pushing both loops toward the drive target, the
    // rest raw noise over the full sample range
    task automatic queue_steered(input int count);
        longint vs;
        longint cs;
        longint cs_center;
        logic [31:0] noise;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 30)
            begin
                noise = $urandom;
                queue_sample(noise[31:16], noise[15:0]);
            end
            else
            begin
                vs = reference_at(planned_loop.phase);
                if (planned_loop.outer_y > 0)
                    vs = vs + longint'($urandom_range(0, 2048));
                else
                    vs = vs - longint'($urandom_range(0, 2048));
                cs_center = clamp_to(planned_loop.outer_y >>> 8, SAMPLE_MIN, SAMPLE_MAX);
                if (planned_loop.inner_y > DRIVE_TARGET)
                    cs = cs_center + longint'($urandom_range(0, 512));
                else
                    cs = cs_center - longint'($urandom_range(0, 512));
                vs = clamp_to(vs, SAMPLE_MIN, SAMPLE_MAX);
                cs = clamp_to(cs, SAMPLE_MIN, SAMPLE_MAX);
                queue_sample(vs[SAMPLE_W-1:0], cs[SAMPLE_W-1:0]);
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || sample_valid || expected_compares.size() != 0);
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else
        begin
            if (sample_valid && sample_ready)
            begin
                predicted = control_tick(tracked_loop, sample);
                expected_compares.push_back(predicted);
                sample_beats++;
            end
            if (!sample_valid || sample_ready)
            begin
                if (pending_samples.size() != 0 && !take_gap())
                begin
                    sample <= pending_samples.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                result_beats++;
                if (expected_compares.size() == 0)
                    report_mismatch($sformatf("result beat %0d with nothing expected",
                        result_beats));
                else
                begin
                    wanted = expected_compares.pop_front();
                    if (result.compare_value !== wanted.compare_value)
                        report_mismatch($sformatf("beat %0d compare_value got %0d want %0d",
                            result_beats, result.compare_value, wanted.compare_value));
                    if (result.compare_clipped !== wanted.compare_clipped)
                        report_mismatch($sformatf("beat %0d compare_clipped got %b want %b",
                            result_beats, result.compare_clipped, wanted.compare_clipped));
                    if (wanted.compare_clipped)
                        clipped_beats++;
                end
            end
            result_ready <= !take_gap();
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || psel || (sample_valid && sample_ready)
                || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // defaults after reset: sample extremes and alternating bit patterns
        settings_used++;
        @(negedge clk);
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'h7FFF, 16'h8000);
        queue_sample(16'h8000, 16'h7FFF);
        queue_sample(16'h8000, 16'h8000);
        queue_sample(16'h7FFF, 16'h7FFF);
        queue_sample(16'h5555, 16'hAAAA);
        queue_sample(16'hAAAA, 16'h5555);
        wait_drained();

        // all ones on the bus: widest gains and amplitude, masked writes,
        // errors and both pid outputs driven into saturation
        write_all('1);
        @(negedge clk);
        queue_sample(16'h8000, 16'h7FFF);
        queue_sample(16'h8000, 16'h7FFF);
        queue_sample(16'h7FFF, 16'h8000);
        queue_sample(16'h7FFF, 16'h8000);
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'h8000, 16'h8000);
        wait_drained();

        // zero gains and amplitude hold the loops still
        write_all('0);
        @(negedge clk);
        queue_sample(16'h3039, 16'hCFC7);
        queue_sample(16'hFFFF, 16'h0001);
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'h7FFF, 16'h8000);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_register(REG_VOLTAGE_KP, pick_gain());
            write_register(REG_VOLTAGE_KI, pick_gain());
            write_register(REG_VOLTAGE_KD, pick_gain());
            write_register(REG_CURRENT_KP, pick_gain());
            write_register(REG_CURRENT_KI, pick_gain());
            write_register(REG_CURRENT_KD, pick_gain());
            write_register(REG_AMPLITUDE, pick_amplitude());
            write_register(UNMAPPED_REG, $urandom);
            settings_used++;
            @(negedge clk);
            steady_flow = (ph == STEADY_PHASE);
            queue_steered(ITEMS_PER_PHASE);
            wait_drained();
            steady_flow = 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_compares.size() != 0)
            report_mismatch($sformatf("%0d compare beats never arrived",
                expected_compares.size()));

        $display("covered %0d sample beats and %0d compare beats (%0d clipped)",
            sample_beats, result_beats, clipped_beats);
        $display("over %0d gain settings, %0d register writes, sine index at %0d",
            settings_used, register_writes, tracked_loop.phase);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/cspvc_pkg.sv
hw/rtl/cspvc_regs.sv
hw/rtl/cspvc_ctrl.sv
hw/rtl/cspvc_dp.sv
hw/rtl/cascaded_sine_voltage_current_pid_unit.sv
test/testbench.sv
